FILE: hw/rtl/lmd_pkg.sv
package lmd_pkg;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 13;
   localparam int WIDTH_BITS     = 11;
   localparam int HEIGHT_BITS    = 13;
   localparam int ROW_BITS       = 13;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [WIDTH_BITS-1:0]  RESET_FRAME_WIDTH  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] RESET_FRAME_HEIGHT = 13'd480;
   localparam logic [HEIGHT_BITS-1:0] MAX_HEIGHT         = 13'd4096;

   typedef struct packed {
      logic [7:0] blue_value;
      logic       flush;
   } lmd_req_type;

   typedef struct packed {
      logic        is_local_min;
      logic [11:0] pixel_row;
      logic [9:0]  pixel_col;
      logic        frame_end;
   } lmd_rsp_type;

   // per-item control from the front to the back, neighbor masks indexed row*3+col
   typedef struct packed {
      logic        emit;
      logic [8:0]  nb_valid;
      logic [11:0] row;
      logic [9:0]  col;
      logic        frame_end;
   } lmd_ctl_type;

endpackage

FILE: hw/rtl/local_minimum_3x3_detect.sv
// 3x3 local minimum detector for a raster-order stream of blue samples.
// req channel: one transfer per pixel (blue_value, flush low) or flush
// padding past the frame end; frame_width + 1 flush transfers push out the
// results still pending for a frame.
// rsp channel: zero or one transfer per request; the result for pixel p
// rides on the transfer caused by request p + frame_width + 1 and passes
// through the queue, the line buffer read and the output register.
// throughput: one request per cycle while req_stall is low; the line buffer
// memories take one read and one write each cycle, the 3x3 compare is combinational.
// csr port: index 0 frame_width, index 1 frame_height; the user writes them
// only while the block is idle, which the block itself does not enforce.
// reset: counters go to zero, frame size to 640x480, window to zero; the
// line buffers keep their contents and need no clearing pass.
// when rsp_stall is high the output register holds, the back end and the
// four-entry queue fill, and req_stall rises once the queue is full.
module local_minimum_3x3_detect #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lmd_pkg::lmd_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lmd_pkg::lmd_rsp_type               rsp_data,
   input  logic                               csr_wr_en,
   input  logic [lmd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lmd_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   import lmd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int QW = $bits(lmd_ctl_type) + CW + PIXEL_BITS;

   logic                  q_full, push_valid, head_valid, pop;
   lmd_ctl_type           push_ctl, head_ctl;
   logic [CW-1:0]         push_idx, head_idx;
   logic [PIXEL_BITS-1:0] push_pix, head_pix;
   logic [QW-1:0]         push_data, head_data;

   assign push_data                      = {push_ctl, push_idx, push_pix};
   assign {head_ctl, head_idx, head_pix} = head_data;

   lmd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_ctl    (push_ctl),
      .push_idx    (push_idx),
      .push_pix    (push_pix)
   );

   lmd_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   lmd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ctl   (head_ctl),
      .head_idx   (head_idx),
      .head_pix   (head_pix),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hw/rtl/lmd_front.sv
module lmd_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lmd_pkg::lmd_req_type                 req_data,
   input  logic                                 csr_wr_en,
   input  logic [lmd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lmd_pkg::CSR_DATA_BITS-1:0]    csr_wr_data,
   input  logic                                 q_full,
   output logic                                 push_valid,
   output lmd_pkg::lmd_ctl_type                 push_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]         push_idx,
   output logic [PIXEL_BITS-1:0]                push_pix
);
   import lmd_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int CW1 = CW + 1;

   logic [WIDTH_BITS-1:0]  w_cfg_ff;
   logic [HEIGHT_BITS-1:0] h_cfg_ff;
   logic [ROW_BITS-1:0]    in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0]          in_col_ff, in_col_in, out_col_ff, out_col_in;

   logic [CW1-1:0]         w_eff, ic_inc, oc_inc;
   logic [HEIGHT_BITS-1:0] h_eff;
   logic [ROW_BITS-1:0]    ir, orw;
   logic [CW-1:0]          ic, oc;
   logic                   accept, restart, drop, emit, col_wrap, out_wrap;
   logic [2:0]             row_ok, col_ok;
   logic [PIXEL_BITS+7:0]  pix_ext;
   logic [CW+9:0]          col_ext;

   assign req_stall = q_full;

   always_comb begin
      if (w_cfg_ff == '0) begin
         w_eff = CW1'(1);
      end else if (32'(w_cfg_ff) > 32'(MAX_WIDTH)) begin
         w_eff = CW1'(MAX_WIDTH);
      end else begin
         w_eff = CW1'(w_cfg_ff);
      end
      if (h_cfg_ff == '0) begin
         h_eff = HEIGHT_BITS'(1);
      end else if (h_cfg_ff > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end else begin
         h_eff = h_cfg_ff;
      end

      accept  = req_valid && !q_full;
      restart = !req_data.flush && (in_row_ff >= h_eff);
      drop    = req_data.flush && ((in_row_ff < h_eff) || (out_row_ff >= h_eff));

      ir  = restart ? '0 : in_row_ff;
      ic  = restart ? '0 : in_col_ff;
      orw = restart ? '0 : out_row_ff;
      oc  = restart ? '0 : out_col_ff;

      emit = (orw < h_eff) && ((ir >= ROW_BITS'(2)) || ((ir == ROW_BITS'(1)) && (ic != '0)));

      row_ok[0] = orw != '0;
      row_ok[1] = 1'b1;
      row_ok[2] = ({1'b0, orw} + 14'd1) < {1'b0, h_eff};
      col_ok[0] = (oc != '0) && ({1'b0, oc} <= w_eff);
      col_ok[1] = {1'b0, oc} < w_eff;
      col_ok[2] = (({1'b0, oc} + CW1'(1)) < w_eff) && (ic != '0);

      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            push_ctl.nb_valid[i*3+j] = row_ok[i] && col_ok[j] && !(i == 1 && j == 1);
         end
      end

      col_ext            = {10'b0, oc};
      push_ctl.emit      = emit;
      push_ctl.row       = orw[11:0];
      push_ctl.col       = col_ext[9:0];
      push_ctl.frame_end = (orw == (h_eff - HEIGHT_BITS'(1))) && ({1'b0, oc} == (w_eff - CW1'(1)));

      pix_ext    = {{PIXEL_BITS{1'b0}}, req_data.blue_value};
      push_pix   = req_data.flush ? '0 : pix_ext[PIXEL_BITS-1:0];
      push_idx   = ic;
      push_valid = accept && !drop;

      ic_inc   = {1'b0, ic} + CW1'(1);
      oc_inc   = {1'b0, oc} + CW1'(1);
      col_wrap = ic_inc >= w_eff;
      out_wrap = oc_inc >= w_eff;

      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (push_valid) begin
         in_col_in  = col_wrap ? '0 : ic_inc[CW-1:0];
         in_row_in  = col_wrap ? ir + ROW_BITS'(1) : ir;
         out_row_in = orw;
         out_col_in = oc;
         if (emit) begin
            out_col_in = out_wrap ? '0 : oc_inc[CW-1:0];
            out_row_in = out_wrap ? orw + ROW_BITS'(1) : orw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_cfg_ff   <= RESET_FRAME_WIDTH;
         h_cfg_ff   <= RESET_FRAME_HEIGHT;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  w_cfg_ff <= csr_wr_data[WIDTH_BITS-1:0];
               CSR_FRAME_HEIGHT: h_cfg_ff <= csr_wr_data[HEIGHT_BITS-1:0];
            endcase
         end
      end
   end

endmodule

FILE: hw/rtl/lmd_queue.sv
module lmd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import lmd_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]    count_ff;

   assign full       = count_ff == NW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         priority if (push_valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push_valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/lmd_back.sv
module lmd_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  lmd_pkg::lmd_ctl_type         head_ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0] head_idx,
   input  logic [PIXEL_BITS-1:0]        head_pix,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output lmd_pkg::lmd_rsp_type         rsp_data
);
   import lmd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];

   logic                  b_valid_ff;
   lmd_ctl_type           b_ctl_ff;
   logic [CW-1:0]         b_idx_ff;
   logic [PIXEL_BITS-1:0] b_pix_ff;
   logic [PIXEL_BITS-1:0] up_rd_ff, mid_rd_ff, fwd_up_ff, fwd_mid_ff;
   logic                  fwd_ff;
   logic [PIXEL_BITS-1:0] win_ff [3][3];
   logic                  rsp_valid_ff;
   lmd_rsp_type           rsp_data_ff;

   logic [PIXEL_BITS-1:0] up_eff, mid_eff, center;
   logic [PIXEL_BITS-1:0] view [9];
   logic                  b_fire, is_min;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      up_eff  = fwd_ff ? fwd_up_ff  : up_rd_ff;
      mid_eff = fwd_ff ? fwd_mid_ff : mid_rd_ff;
      b_fire  = b_valid_ff && (!b_ctl_ff.emit || !rsp_valid_ff || !rsp_stall);
      pop     = head_valid && (!b_valid_ff || b_fire);

      // window after the shift, new column on the right
      for (int i = 0; i < 3; i++) begin
         view[i*3]   = win_ff[i][1];
         view[i*3+1] = win_ff[i][2];
      end
      view[2] = up_eff;
      view[5] = mid_eff;
      view[8] = b_pix_ff;
      center  = win_ff[1][2];

      is_min = 1'b1;
      for (int k = 0; k < 9; k++) begin
         if (b_ctl_ff.nb_valid[k] && (center > view[k])) begin
            is_min = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         upper_mem[b_idx_ff]  <= mid_eff;
         middle_mem[b_idx_ff] <= b_pix_ff;
      end
      if (pop) begin
         up_rd_ff   <= upper_mem[head_idx];
         mid_rd_ff  <= middle_mem[head_idx];
         fwd_up_ff  <= mid_eff;
         fwd_mid_ff <= b_pix_ff;
         b_ctl_ff   <= head_ctl;
         b_idx_ff   <= head_idx;
         b_pix_ff   <= head_pix;
      end
      if (b_fire && b_ctl_ff.emit) begin
         rsp_data_ff.is_local_min <= is_min;
         rsp_data_ff.pixel_row    <= b_ctl_ff.row;
         rsp_data_ff.pixel_col    <= b_ctl_ff.col;
         rsp_data_ff.frame_end    <= b_ctl_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         if (pop) begin
            b_valid_ff <= 1'b1;
            // same entry written at this edge, so the read comes back stale
            fwd_ff     <= b_fire && (b_idx_ff == head_idx);
         end else if (b_fire) begin
            b_valid_ff <= 1'b0;
         end
         if (b_fire) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= up_eff;
            win_ff[1][2] <= mid_eff;
            win_ff[2][2] <= b_pix_ff;
         end
         if (b_fire && b_ctl_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: sim/local_minimum_3x3_detect_tb.sv
module local_minimum_3x3_detect_tb;
   import lmd_pkg::*;

   localparam int LINE_DEPTH   = 1024;
   localparam int SETTLE       = 8;
   localparam int QUIET_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 300;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   lmd_req_type               req_data;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   lmd_rsp_type               rsp_data;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data;

   local_minimum_3x3_detect dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // detector state as seen from the stream
   logic [7:0]       upper_px [LINE_DEPTH];
   logic [7:0]       middle_px [LINE_DEPTH];
   logic [7:0]       window_px [3][3];
   logic [WIDTH_BITS-1:0]  width_reg;
   logic [HEIGHT_BITS-1:0] height_reg;
   int unsigned      feed_row, feed_col, judge_row, judge_col;

   lmd_rsp_type      pending_minima [$];
   lmd_rsp_type      want_rsp;
   int unsigned      error_count = 0;
   int unsigned      items_done = 0;
   int unsigned      quiet_cycles = 0;
   bit               bursty = 1'b1;
   int unsigned      burst_left = 0;

   int unsigned      hold_request = 0;
   int unsigned      hold_left = 0;
   int unsigned      stall_mode = 0;
   int unsigned      phase_left = 0;

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   function automatic void clear_detector();
      foreach (upper_px[i]) begin
         upper_px[i] = '0;
         middle_px[i] = '0;
      end
      foreach (window_px[i, j]) window_px[i][j] = '0;
      width_reg = RESET_FRAME_WIDTH;
      height_reg = RESET_FRAME_HEIGHT;
      feed_row = 0;
      feed_col = 0;
      judge_row = 0;
      judge_col = 0;
   endfunction

   // shift selects the window column that holds the left neighbors
   function automatic bit window_is_min(int unsigned w, int unsigned h, int shift);
      logic [7:0] center;
      int r, c;
      center = window_px[1][1 + shift];
      for (int i = 0; i < 3; i++) begin
         r = int'(judge_row) - 1 + i;
         if (r < 0 || r >= int'(h)) continue;
         for (int j = 0; j < 3; j++) begin
            c = int'(judge_col) - 1 + j;
            if (c < 0 || c >= int'(w)) continue;
            if (i == 1 && j == 1) continue;
            if (j + shift > 2) continue;
            if (center > window_px[i][j + shift]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void scan_pixel(input lmd_req_type item, output bit taken,
                                      output bit has_result, output lmd_rsp_type result);
      int unsigned w, h, idx;
      logic [7:0]  px;
      bit          is_min;
      w = eff_width();
      h = eff_height();
      taken = 1'b0;
      has_result = 1'b0;
      result = '0;
      is_min = 1'b0;
      px = item.flush ? 8'd0 : item.blue_value;
      if (!item.flush) begin
         if (feed_row >= h) begin
            feed_row = 0;
            feed_col = 0;
            judge_row = 0;
            judge_col = 0;
         end
      end else if (feed_row < h || judge_row >= h) begin
         return;
      end
      taken = 1'b1;
      has_result = judge_row < h && (feed_row >= 2 || (feed_row == 1 && feed_col >= 1));
      if (has_result && feed_col == 0) is_min = window_is_min(w, h, 1);
      idx = feed_col < LINE_DEPTH ? feed_col : LINE_DEPTH - 1;
      for (int i = 0; i < 3; i++) begin
         window_px[i][0] = window_px[i][1];
         window_px[i][1] = window_px[i][2];
      end
      window_px[0][2] = upper_px[idx];
      window_px[1][2] = middle_px[idx];
      window_px[2][2] = px;
      upper_px[idx] = middle_px[idx];
      middle_px[idx] = px;
      if (has_result && feed_col != 0) is_min = window_is_min(w, h, 0);
      feed_col++;
      if (feed_col >= w) begin
         feed_col = 0;
         feed_row++;
      end
      if (!has_result) return;
      result.is_local_min = is_min;
      result.pixel_row = 12'(judge_row);
      result.pixel_col = 10'(judge_col);
      result.frame_end = judge_row == h - 1 && judge_col == w - 1;
      judge_col++;
      if (judge_col >= w) begin
         judge_col = 0;
         judge_row++;
      end
   endfunction

   function automatic logic [7:0] random_blue();
      case ($urandom_range(0, 5))
         0, 1: return 8'($urandom_range(0, 255));
         2, 3: return 8'($urandom_range(0, 3));
         4: return 8'($urandom_range(250, 255));
         default: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      endcase
   endfunction

   function automatic lmd_req_type pixel_item(logic [7:0] value);
      return lmd_req_type'{blue_value: value, flush: 1'b0};
   endfunction

   function automatic lmd_req_type flush_item();
      return lmd_req_type'{blue_value: 8'($urandom_range(0, 255)), flush: 1'b1};
   endfunction

   function automatic void report_field(string field, int unsigned want, int unsigned got);
      error_count++;
      $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
   endfunction

   task automatic send_item(input lmd_req_type item);
      int unsigned gap;
      bit          taken, has_result;
      lmd_rsp_type result;
      if (bursty) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clock) req_valid <= 1'b0;
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 40);
         end
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      scan_pixel(item, taken, has_result, result);
      if (has_result) pending_minima.push_back(result);
      if (taken) items_done++;
   endtask

   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_minima.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      @(negedge clock) csr_wr_en <= 1'b0;
      if (index == CSR_FRAME_WIDTH) width_reg = data[WIDTH_BITS-1:0];
      else height_reg = data[HEIGHT_BITS-1:0];
   endtask

   task automatic set_frame(input logic [CSR_DATA_BITS-1:0] w,
                            input logic [CSR_DATA_BITS-1:0] h);
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   task automatic flush_out(input int unsigned extra);
      while (judge_row < eff_height()) send_item(flush_item());
      repeat (extra) send_item(flush_item());
   endtask

   task automatic run_frame(input bit noisy, input bit truncate, input int unsigned extra);
      int unsigned h, cut;
      h = eff_height();
      do begin
         send_item(pixel_item(random_blue()));
         if (noisy && feed_row < h && $urandom_range(0, 15) == 0) send_item(flush_item());
      end while (feed_row < h);
      if (truncate) begin
         cut = $urandom_range(0, eff_width());
         for (int k = 0; k < cut && judge_row < h; k++) send_item(flush_item());
      end else begin
         flush_out(extra);
      end
   endtask

   // one full saturated row, then a few flush transfers that only count once the row ends
   task automatic test_widest_frame();
      set_frame(13'd2047, 13'd1);
      repeat (LINE_DEPTH) send_item(pixel_item(random_blue()));
      repeat (2) send_item(flush_item());
   endtask

   task automatic test_single_pixel();
      set_frame(13'd0, 13'd0);
      send_item(pixel_item(8'hff));
      flush_out(2);
   endtask

   task automatic test_plateau();
      logic [7:0] values [9] = '{8'd4, 8'd4, 8'd9, 8'd4, 8'd4, 8'd9, 8'd255, 8'd0, 8'd255};
      set_frame(13'd3, 13'd3);
      foreach (values[k]) begin
         send_item(pixel_item(values[k]));
         if (k == 3) send_item(flush_item());
      end
      flush_out(2);
   endtask

   task automatic test_pixel_after_frame();
      set_frame(13'd2, 13'd2);
      send_item(pixel_item(8'd0));
      send_item(pixel_item(8'd255));
      send_item(pixel_item(8'd255));
      send_item(pixel_item(8'd0));
      send_item(flush_item());
      send_item(pixel_item(8'd7));
      run_frame(1'b0, 1'b0, 0);
   endtask

   task automatic test_resize_mid_frame();
      set_frame(13'd4, 13'd4);
      repeat (7) send_item(pixel_item(random_blue()));
      set_frame(13'd2, 13'd3);
      run_frame(1'b0, 1'b0, 1);
   endtask

   task automatic test_tallest_frame();
      set_frame(13'd1, 13'd8191);
      repeat (40) send_item(pixel_item(random_blue()));
   endtask

   task automatic test_stall_fill();
      set_frame(13'd5, 13'd20);
      bursty = 1'b0;
      hold_request = 200;
      run_frame(1'b0, 1'b0, 0);
      bursty = 1'b1;
   endtask

   task automatic test_drain_pause();
      set_frame(13'd6, 13'd6);
      for (int k = 0; k < 36; k++) begin
         send_item(pixel_item(random_blue()));
         if (k % 8 == 7) wait_idle();
      end
      flush_out(0);
   endtask

   task automatic test_random_frames();
      int unsigned target, w, h;
      target = items_done + RANDOM_ITEMS;
      while (items_done < target) begin
         if ($urandom_range(0, 2) != 0) begin
            w = $urandom_range(0, 9) == 0 ? $urandom_range(9, 48) : $urandom_range(0, 8);
            h = $urandom_range(0, 9) == 0 ? $urandom_range(9, 24) : $urandom_range(0, 8);
            set_frame(13'(w) | 13'($urandom_range(0, 3) << WIDTH_BITS), 13'(h));
         end
         run_frame($urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0, $urandom_range(0, 2));
         if ($urandom_range(0, 9) == 0) wait_idle();
      end
   endtask

   // receiver: random stall phases, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(5, 80);
         end
         phase_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 99) < 30;
            2: rsp_stall <= $urandom_range(0, 99) < 75;
            default: rsp_stall <= phase_left % 4 == 0;
         endcase
      end
   end

   // result transfer check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_minima.size() == 0) begin
            report_field("result with none pending, pixel_row", 0, rsp_data.pixel_row);
         end else begin
            want_rsp = pending_minima.pop_front();
            if (rsp_data.is_local_min !== want_rsp.is_local_min)
               report_field("is_local_min", want_rsp.is_local_min, rsp_data.is_local_min);
            if (rsp_data.pixel_row !== want_rsp.pixel_row)
               report_field("pixel_row", want_rsp.pixel_row, rsp_data.pixel_row);
            if (rsp_data.pixel_col !== want_rsp.pixel_col)
               report_field("pixel_col", want_rsp.pixel_col, rsp_data.pixel_col);
            if (rsp_data.frame_end !== want_rsp.frame_end)
               report_field("frame_end", want_rsp.frame_end, rsp_data.frame_end);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("local_minimum_3x3_detect: mismatch");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      clear_detector();
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_widest_frame();
      test_single_pixel();
      test_plateau();
      test_pixel_after_frame();
      test_resize_mid_frame();
      test_tallest_frame();
      test_stall_fill();
      test_drain_pause();
      test_random_frames();
      wait_idle();
      if (error_count == 0 && pending_minima.size() == 0) begin
         $display("local_minimum_3x3_detect: match");
      end else begin
         $display("local_minimum_3x3_detect: mismatch");
      end
      $finish;
   end

endmodule

FILE: local_minimum_3x3_detect.f
hw/rtl/lmd_pkg.sv
hw/rtl/lmd_front.sv
hw/rtl/lmd_queue.sv
hw/rtl/lmd_back.sv
hw/rtl/local_minimum_3x3_detect.sv
sim/local_minimum_3x3_detect_tb.sv
